FILE: rtl/core/io_latency_histogram_monitor_top_defines.svh
// ----------------------------------------------------------------------------
// io latency histogram monitor assertion macros
// shared concurrent assertion forms, all clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef IO_LATENCY_HISTOGRAM_MONITOR_TOP_DEFINES_SVH
`define IO_LATENCY_HISTOGRAM_MONITOR_TOP_DEFINES_SVH

// same-cycle implication
`define ILHM_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ILHM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/ilhm_pkg.sv
// ----------------------------------------------------------------------------
// ilhm_pkg
// types, constants and helper functions of the io latency histogram monitor
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ilhm_pkg;

  localparam int HISTORY_DEPTH_DEFAULT = 4;
  localparam int SHOWN_ENTRIES         = 4;
  localparam int NUM_BUCKETS           = 8;
  localparam int BUCKET_W              = 3;

  // register map
  localparam int          ADDR_W          = 4;
  localparam logic        REG_RATE_WINDOW = 1'b0;
  localparam logic [63:0] RATE_WINDOW_RST = 64'd1_000_000_000;

  // ns to us: shift out a factor of 8, then divide by 125 in 16-bit digits
  localparam int          NS_PER_US   = 1000;
  localparam int          PRESHIFT    = 3;
  localparam int          DIV_BASE    = NS_PER_US >> PRESHIFT;
  localparam int          RECIP_SHIFT = 23;
  localparam logic [16:0] RECIP_BASE  = 17'((64'd1 << RECIP_SHIFT) / DIV_BASE);
  localparam int          DIGIT_W     = 16;
  localparam int          DIV_STAGES  = 4;

  localparam logic [31:0] BUCKET_LIMITS [NUM_BUCKETS-1] = '{
    32'd100, 32'd500, 32'd1000, 32'd5000, 32'd10000, 32'd50000, 32'd100000
  };

  typedef struct packed {
    logic [15:0] quo;
    logic [6:0]  rem;
  } div_step_t;

  // one long-division digit: ({rem, digit}) / 125, reciprocal estimate plus one fix-up
  function automatic div_step_t div_step(input logic [6:0] rem, input logic [15:0] digit);
    logic [22:0] num;
    logic [39:0] prod;
    logic [15:0] q_est;
    logic [22:0] r_est;
    div_step_t   res;
    num   = {rem, digit};
    prod  = 40'(num) * 40'(RECIP_BASE);
    q_est = prod[RECIP_SHIFT +: 16];
    r_est = num - 23'(q_est) * 23'(DIV_BASE);
    if (r_est >= 23'(DIV_BASE)) begin
      res.quo = q_est + 16'd1;
      res.rem = 7'(r_est - 23'(DIV_BASE));
    end else begin
      res.quo = q_est;
      res.rem = 7'(r_est);
    end
    return res;
  endfunction

  // bucket = number of bounds at or below the latency
  function automatic logic [2:0] pick_bucket(input logic [31:0] lat);
    logic [2:0] b;
    b = '0;
    for (int i = 0; i < NUM_BUCKETS - 1; i++) begin
      if (lat >= BUCKET_LIMITS[i]) begin
        b = 3'(i + 1);
      end
    end
    return b;
  endfunction

endpackage

FILE: rtl/core/io_latency_histogram_monitor_top.sv
// ----------------------------------------------------------------------------
// io_latency_histogram_monitor_top
// latency histogram, totals, rate window count and short latency history
// ----------------------------------------------------------------------------
// Takes one completed i/o request per item (issue and completion time in ns)
// and returns one result item per request: the latency in us, its histogram
// bucket with the bucket's updated count, the updated request total and
// latency sum, the rate window count and the last four latencies. The block
// accepts a new item every cycle while the result side keeps up. Each item
// passes seven registers (input subtract, four divide-by-125 digit stages,
// bucket select, result register) before its result item is presented. That
// depth is set by the ns-to-us conversion, which is done as a long division
// one 16-bit digit per stage. A stalled result holds the pipeline behind it.
// All histogram and counter state is updated in order as an item enters the
// result register. No item is taken while rst is high. The window length is
// written through the apb port at byte address 0; the user must write it
// only while the block is idle, as the block itself does not enforce it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "io_latency_histogram_monitor_top_defines.svh"

module io_latency_histogram_monitor_top #(
  parameter int HISTORY_DEPTH = ilhm_pkg::HISTORY_DEPTH_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,

  // apb configuration port
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [ilhm_pkg::ADDR_W-1:0] paddr,
  input  logic [63:0]               pwdata,
  output logic [63:0]               prdata,
  output logic                      pready,

  // request item channel
  input  logic                      item_valid,
  output logic                      item_ready,
  input  logic [63:0]               issue_time_ns,
  input  logic [63:0]               complete_time_ns,

  // result item channel
  output logic                      result_valid,
  input  logic                      result_ready,
  output logic [31:0]               req_latency_us,
  output logic [2:0]                bucket_index,
  output logic [63:0]               bucket_count,
  output logic [63:0]               total_requests,
  output logic [63:0]               latency_sum_us,
  output logic [31:0]               window_requests,
  output logic [31:0]               recent_lat_0,
  output logic [31:0]               recent_lat_1,
  output logic [31:0]               recent_lat_2,
  output logic [31:0]               recent_lat_3
);

  localparam int NDIV = ilhm_pkg::DIV_STAGES;
  localparam int XW   = 64 - ilhm_pkg::PRESHIFT;

  // --------------------------------------------------------------------------
  // configuration register
  // --------------------------------------------------------------------------
  logic [63:0] rate_window;
  logic        reg_sel;

  assign reg_sel = (paddr[ilhm_pkg::ADDR_W-1] == ilhm_pkg::REG_RATE_WINDOW);
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? rate_window : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      rate_window <= ilhm_pkg::RATE_WINDOW_RST;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      rate_window <= pwdata;
    end
  end

  // --------------------------------------------------------------------------
  // pipeline flow control: a stage loads when it is empty or its content moves on
  // --------------------------------------------------------------------------
  logic          pv   [0:NDIV];
  logic          adv  [0:NDIV];
  logic [XW-1:0] px   [0:NDIV-1];
  logic [63:0]   pnow [0:NDIV];
  logic [6:0]    prem [1:NDIV-1];
  logic [31:0]   pq   [1:NDIV];

  logic        ev;
  logic        adv_e;
  logic [31:0] elat;
  logic [2:0]  ebkt;
  logic [63:0] enow;

  logic        adv_o;
  logic        load_o;

  assign adv_o      = !result_valid || result_ready;
  assign load_o     = adv_o && ev;
  assign adv_e      = !ev || adv_o;
  assign adv[NDIV]  = !pv[NDIV] || adv_e;
  // no item is taken while in reset
  assign item_ready = adv[0] && !rst;

  // --------------------------------------------------------------------------
  // input stage: elapsed ns, with the factor of 8 of 1000 shifted out
  // --------------------------------------------------------------------------
  logic [63:0] diff_ns;
  assign diff_ns = complete_time_ns - issue_time_ns;

  always_ff @(posedge clk) begin
    if (rst) begin
      pv[0] <= 1'b0;
    end else if (adv[0]) begin
      pv[0] <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      px[0]   <= diff_ns[63:ilhm_pkg::PRESHIFT];
      pnow[0] <= complete_time_ns;
    end
  end

  // --------------------------------------------------------------------------
  // divide by 125, most significant 16-bit digit first, one digit per stage;
  // only the low 32 quotient bits are kept (latency wraps to 32 bits)
  // --------------------------------------------------------------------------
  for (genvar k = 0; k < NDIV; k++) begin : g_div
    localparam int Hi = 63 - ilhm_pkg::DIGIT_W * k;

    logic [63:0]         xw;
    logic [6:0]          rem_in;
    logic [31:0]         q_in;
    ilhm_pkg::div_step_t step;

    assign xw = {{ilhm_pkg::PRESHIFT{1'b0}}, px[k]};

    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign q_in   = '0;
    end else begin : g_rest
      assign rem_in = prem[k];
      assign q_in   = pq[k];
    end

    assign step   = ilhm_pkg::div_step(rem_in, xw[Hi -: ilhm_pkg::DIGIT_W]);
    assign adv[k] = (k == NDIV) ? 1'b0 : (!pv[k] || adv[k+1]);

    always_ff @(posedge clk) begin
      if (rst) begin
        pv[k+1] <= 1'b0;
      end else if (adv[k+1]) begin
        pv[k+1] <= pv[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv[k+1]) begin
        pq[k+1]   <= {q_in[15:0], step.quo};
        pnow[k+1] <= pnow[k];
      end
    end

    // the last stage carries no dividend or remainder onward
    if (k < NDIV - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (adv[k+1]) begin
          px[k+1]   <= px[k];
          prem[k+1] <= step.rem;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // bucket select stage
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      ev <= 1'b0;
    end else if (adv_e) begin
      ev <= pv[NDIV];
    end
  end

  always_ff @(posedge clk) begin
    if (adv_e) begin
      elat <= pq[NDIV];
      ebkt <= ilhm_pkg::pick_bucket(pq[NDIV]);
      enow <= pnow[NDIV];
    end
  end

  // --------------------------------------------------------------------------
  // state update and result register; state changes only when an item
  // enters the result register, so counters and history read out directly
  // --------------------------------------------------------------------------
  logic [63:0] bucket_counters [ilhm_pkg::NUM_BUCKETS];
  logic [63:0] request_total;
  logic [63:0] latency_total;
  logic [31:0] latency_history [HISTORY_DEPTH];
  logic [31:0] window_count;
  logic [63:0] window_start;

  logic [63:0] bucket_count_next;
  logic [63:0] elapsed;
  logic        window_over;

  assign bucket_count_next = bucket_counters[ebkt] + 64'd1;
  assign elapsed           = enow - window_start;
  assign window_over       = elapsed > rate_window;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv_o) begin
      result_valid <= ev;
    end
  end

  always_ff @(posedge clk) begin
    if (load_o) begin
      req_latency_us <= elat;
      bucket_index   <= ebkt;
      bucket_count   <= bucket_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ilhm_pkg::NUM_BUCKETS; i++) begin
        bucket_counters[i] <= '0;
      end
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        latency_history[i] <= '0;
      end
      request_total <= '0;
      latency_total <= '0;
      window_count  <= '0;
      window_start  <= '0;
    end else if (load_o) begin
      bucket_counters[ebkt] <= bucket_count_next;
      for (int i = 0; i < HISTORY_DEPTH - 1; i++) begin
        latency_history[i] <= latency_history[i+1];
      end
      latency_history[HISTORY_DEPTH-1] <= elat;
      request_total <= request_total + 64'd1;
      latency_total <= latency_total + 64'(elat);
      // window restarts at this request when too much time has gone by
      if (window_over) begin
        window_count <= 32'd1;
        window_start <= enow;
      end else begin
        window_count <= window_count + 32'd1;
      end
    end
  end

  assign total_requests  = request_total;
  assign latency_sum_us  = latency_total;
  assign window_requests = window_count;

  // newest four history entries, oldest first; missing entries read zero
  logic [31:0] shown [ilhm_pkg::SHOWN_ENTRIES];

  for (genvar j = 0; j < ilhm_pkg::SHOWN_ENTRIES; j++) begin : g_shown
    localparam int Pos = HISTORY_DEPTH - ilhm_pkg::SHOWN_ENTRIES + j;
    if (Pos >= 0) begin : g_entry
      assign shown[j] = latency_history[Pos];
    end else begin : g_none
      assign shown[j] = '0;
    end
  end

  assign recent_lat_0 = shown[0];
  assign recent_lat_1 = shown[1];
  assign recent_lat_2 = shown[2];
  assign recent_lat_3 = shown[3];

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  `ILHM_ASSERT_IMPLY(a_newest_is_latency, result_valid, recent_lat_3 == req_latency_us, "newest history entry differs from latency")
  `ILHM_ASSERT_NEXT(a_total_steps, load_o, total_requests == $past(request_total) + 64'd1, "request total did not advance by one")
  `ILHM_ASSERT_NEXT(a_sum_steps, load_o, latency_sum_us == $past(latency_total) + 64'($past(elat)), "latency sum did not add the latency")
  `ILHM_ASSERT_NEXT(a_no_update_idle, !load_o, $stable(request_total) && $stable(window_count), "counters changed without an item")

endmodule

FILE: bench/io_latency_histogram_monitor_top_tb.sv
// ----------------------------------------------------------------------------
// io_latency_histogram_monitor_top_tb
// self-checking bench for the latency histogram monitor
// ----------------------------------------------------------------------------
// Requests are sent on the item channel while a scoreboard process checks
// every result item against a bench-side model of the histogram, the
// totals, the rate window and the latency history. A directed part covers
// the bucket bounds, the timestamp extremes and the window register corner
// cases. A random part then runs several window settings with a mix of
// well-formed request streams, noise and backward time steps, and random
// idling on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module io_latency_histogram_monitor_top_tb;

  localparam int          HALF_PERIOD   = 6;
  localparam int          CYCLE_LIMIT   = 400000;
  localparam int          DRAIN_CYCLES  = 16;
  localparam int          PHASE_ITEMS   = 105;
  localparam logic [63:0] NS_IN_US      = 64'd1000;
  localparam logic [63:0] ALL_ONES      = 64'hFFFF_FFFF_FFFF_FFFF;

  // window register sits at byte 0; byte 8 decodes to nothing
  localparam logic [ilhm_pkg::ADDR_W-1:0] WINDOW_ADDR   = {ilhm_pkg::REG_RATE_WINDOW, 3'b000};
  localparam logic [ilhm_pkg::ADDR_W-1:0] UNMAPPED_ADDR = 4'h8;

  // upper bounds (us) of buckets 0..6, bucket 7 takes the rest
  localparam logic [31:0] LAT_BOUNDS_US [ilhm_pkg::NUM_BUCKETS-1] = '{
    32'd100, 32'd500, 32'd1000, 32'd5000, 32'd10000, 32'd50000, 32'd100000
  };

  typedef struct packed {
    logic [31:0] lat;
    logic [2:0]  bucket;
    logic [63:0] bucket_cnt;
    logic [63:0] total;
    logic [63:0] lat_sum;
    logic [31:0] win_reqs;
    logic [31:0] hist0;
    logic [31:0] hist1;
    logic [31:0] hist2;
    logic [31:0] hist3;
  } lat_result_t;

  // ---------------------------------------------------------------------------
  // dut signals
  // ---------------------------------------------------------------------------
  logic                        clk;
  logic                        rst;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [ilhm_pkg::ADDR_W-1:0] paddr;
  logic [63:0]                 pwdata;
  logic [63:0]                 prdata;
  logic                        pready;
  logic                        item_valid;
  logic                        item_ready;
  logic [63:0]                 issue_time_ns;
  logic [63:0]                 complete_time_ns;
  logic                        result_valid;
  logic                        result_ready;
  logic [31:0]                 req_latency_us;
  logic [2:0]                  bucket_index;
  logic [63:0]                 bucket_count;
  logic [63:0]                 total_requests;
  logic [63:0]                 latency_sum_us;
  logic [31:0]                 window_requests;
  logic [31:0]                 recent_lat_0;
  logic [31:0]                 recent_lat_1;
  logic [31:0]                 recent_lat_2;
  logic [31:0]                 recent_lat_3;

  io_latency_histogram_monitor_top u_dut (
    .clk              (clk),
    .rst              (rst),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .item_valid       (item_valid),
    .item_ready       (item_ready),
    .issue_time_ns    (issue_time_ns),
    .complete_time_ns (complete_time_ns),
    .result_valid     (result_valid),
    .result_ready     (result_ready),
    .req_latency_us   (req_latency_us),
    .bucket_index     (bucket_index),
    .bucket_count     (bucket_count),
    .total_requests   (total_requests),
    .latency_sum_us   (latency_sum_us),
    .window_requests  (window_requests),
    .recent_lat_0     (recent_lat_0),
    .recent_lat_1     (recent_lat_1),
    .recent_lat_2     (recent_lat_2),
    .recent_lat_3     (recent_lat_3)
  );

  // ---------------------------------------------------------------------------
  // bench state
  // ---------------------------------------------------------------------------
  // mirror of the monitor state, updated as each request item is accepted
  logic [63:0] bucket_hits [ilhm_pkg::NUM_BUCKETS];
  logic [63:0] seen_requests;
  logic [63:0] lat_accum;
  logic [31:0] lat_hist [ilhm_pkg::SHOWN_ENTRIES];
  logic [31:0] win_reqs;
  logic [63:0] win_open_ns;
  logic [63:0] win_len_ns;

  lat_result_t predicted_results [$];
  lat_result_t due;

  int          errors;
  int          cycles;
  int          stall_left;
  bit          sender_idles;
  bit          receiver_stalls;
  logic [63:0] clock_ns;

  // ---------------------------------------------------------------------------
  // clock, watchdog
  // ---------------------------------------------------------------------------
  initial clk = 1'b0;
  always #HALF_PERIOD clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("io_latency_histogram_monitor_top regression: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // idle lengths: mostly short, now and then long
  // ---------------------------------------------------------------------------
  function automatic int idle_len();
    if ($urandom_range(0, 99) < 80) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(6, 24);
  endfunction

  // ---------------------------------------------------------------------------
  // monitor model: account one accepted request and queue its result item
  // ---------------------------------------------------------------------------
  task automatic account_request(input logic [63:0] st, input logic [63:0] ct);
    logic [31:0] lat;
    logic [2:0]  b;
    lat_result_t r;
    // truncating divide of the wrapped difference, then keep the low 32 bits
    lat = 32'((ct - st) / NS_IN_US);
    for (int i = 0; i < ilhm_pkg::SHOWN_ENTRIES - 1; i++) begin
      lat_hist[i] = lat_hist[i + 1];
    end
    lat_hist[ilhm_pkg::SHOWN_ENTRIES - 1] = lat;
    // count first, then restart when strictly more than the window has passed
    win_reqs = win_reqs + 32'd1;
    if (ct - win_open_ns > win_len_ns) begin
      win_reqs    = 32'd1;
      win_open_ns = ct;
    end
    seen_requests = seen_requests + 64'd1;
    lat_accum     = lat_accum + 64'(lat);
    b = 3'd0;
    while (b < 3'(ilhm_pkg::NUM_BUCKETS - 1) && lat >= LAT_BOUNDS_US[b]) begin
      b = b + 3'd1;
    end
    bucket_hits[b] = bucket_hits[b] + 64'd1;
    r.lat        = lat;
    r.bucket     = b;
    r.bucket_cnt = bucket_hits[b];
    r.total      = seen_requests;
    r.lat_sum    = lat_accum;
    r.win_reqs   = win_reqs;
    r.hist0      = lat_hist[0];
    r.hist1      = lat_hist[1];
    r.hist2      = lat_hist[2];
    r.hist3      = lat_hist[3];
    predicted_results.push_back(r);
  endtask

  // ---------------------------------------------------------------------------
  // request sender: optional gap, then hold valid until accepted
  // ---------------------------------------------------------------------------
  task automatic send_request(input logic [63:0] st, input logic [63:0] ct);
    int gap;
    gap = 0;
    if (sender_idles && $urandom_range(0, 99) < 30) begin
      gap = idle_len();
    end
    @(negedge clk);
    if (gap > 0) begin
      item_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    issue_time_ns    = st;
    complete_time_ns = ct;
    item_valid       = 1'b1;
    do @(posedge clk); while (!item_ready);
    account_request(st, ct);
  endtask

  // lower valid and let every expected result item come back
  task automatic wait_idle();
    @(negedge clk);
    item_valid = 1'b0;
    while (predicted_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // apb write: setup cycle, then access cycle until pready
  task automatic apb_write(input logic [ilhm_pkg::ADDR_W-1:0] addr, input logic [63:0] data);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = addr;
    pwdata  = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    // writes to any address with bit 3 set are dropped by the block
    if (addr == WINDOW_ADDR) begin
      win_len_ns = data;
    end
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // result side: random back-pressure, applied at the falling edge
  // ---------------------------------------------------------------------------
  initial begin
    result_ready = 1'b0;
    stall_left   = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        result_ready = 1'b0;
        stall_left   = stall_left - 1;
      end else if (receiver_stalls && $urandom_range(0, 99) < 20) begin
        result_ready = 1'b0;
        stall_left   = idle_len() - 1;
      end else begin
        result_ready = 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // scoreboard: each accepted result item against the oldest prediction
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors = errors + 1;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      if (predicted_results.size() == 0) begin
        $error("result item with no request outstanding");
        errors = errors + 1;
      end else begin
        due = predicted_results.pop_front();
        check_field("req_latency_us",  64'(due.lat),        64'(req_latency_us));
        check_field("bucket_index",    64'(due.bucket),     64'(bucket_index));
        check_field("bucket_count",    due.bucket_cnt,      bucket_count);
        check_field("total_requests",  due.total,           total_requests);
        check_field("latency_sum_us",  due.lat_sum,         latency_sum_us);
        check_field("window_requests", 64'(due.win_reqs),   64'(window_requests));
        check_field("recent_lat_0",    64'(due.hist0),      64'(recent_lat_0));
        check_field("recent_lat_1",    64'(due.hist1),      64'(recent_lat_1));
        check_field("recent_lat_2",    64'(due.hist2),      64'(recent_lat_2));
        check_field("recent_lat_3",    64'(due.hist3),      64'(recent_lat_3));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  // latencies on both sides of every bucket bound, plus timestamp extremes
  task automatic test_bucket_bounds();
    logic [63:0] origin;
    logic [63:0] bound_ns;
    origin = {$urandom, $urandom} >> 1;
    // zero latency and a sub-microsecond one that truncates to zero
    send_request(origin, origin);
    send_request(origin, origin + 64'd999);
    for (int i = 0; i < ilhm_pkg::NUM_BUCKETS - 1; i++) begin
      bound_ns = 64'(LAT_BOUNDS_US[i]) * NS_IN_US;
      send_request(origin, origin + bound_ns - 64'd1);
      send_request(origin, origin + bound_ns);
    end
    // largest latency that fits in 32 bits, and the first one that wraps
    send_request(64'd0, 64'h0000_0000_FFFF_FFFF * NS_IN_US + 64'd999);
    send_request(64'd0, 64'h0000_0001_0000_0000 * NS_IN_US);
    // completion before start, where the difference wraps, and the widest span
    send_request(origin + 64'd1, origin);
    send_request(64'd0, ALL_ONES);
    send_request(ALL_ONES, 64'd0);
  endtask

  // window register corner cases, including a write to an unmapped address
  task automatic test_window_register();
    logic [63:0] t;
    t = 64'h0000_1234_0000_0000;
    // zero window: only an elapsed time of zero keeps the window open
    wait_idle();
    apb_write(WINDOW_ADDR, 64'd0);
    send_request(t - 64'd5000, t);
    send_request(t - 64'd7000, t);
    send_request(t - 64'd7000, t + 64'd1);
    // widest window: time going backwards still stays inside it
    wait_idle();
    apb_write(WINDOW_ADDR, ALL_ONES);
    send_request(t - 64'd500_000, t - 64'd100);
    send_request(64'd0, 64'd10);
    // one-nanosecond window: restart only past one ns
    wait_idle();
    apb_write(WINDOW_ADDR, 64'd1);
    send_request(64'd0, 64'd2000);
    send_request(64'd0, 64'd2001);
    send_request(64'd0, 64'd2003);
    // unmapped write must leave the window as it is
    wait_idle();
    apb_write(UNMAPPED_ADDR, 64'h5A5A_5A5A_5A5A_5A5A);
    send_request(64'd0, 64'd2004);
    send_request(64'd0, 64'd2006);
  endtask

  // latency drawn from a random bucket, sometimes past 32 bits of us
  function automatic logic [63:0] pick_latency_ns();
    int          k;
    logic [63:0] us;
    k = $urandom_range(0, ilhm_pkg::NUM_BUCKETS);
    if (k == 0) begin
      us = 64'($urandom_range(0, LAT_BOUNDS_US[0] - 1));
    end else if (k < ilhm_pkg::NUM_BUCKETS - 1) begin
      us = 64'($urandom_range(LAT_BOUNDS_US[k - 1], LAT_BOUNDS_US[k] - 1));
    end else if (k == ilhm_pkg::NUM_BUCKETS - 1) begin
      us = 64'($urandom_range(LAT_BOUNDS_US[ilhm_pkg::NUM_BUCKETS - 2], 3_000_000));
    end else begin
      us = 64'($urandom) << $urandom_range(0, 8);
    end
    return us * NS_IN_US + 64'($urandom_range(0, 999));
  endfunction

  // mostly an advancing completion clock, some noise and backward steps
  task automatic next_request(output logic [63:0] st, output logic [63:0] ct);
    int r;
    int s;
    r = $urandom_range(0, 99);
    if (r < 82) begin
      s = $urandom_range(0, 99);
      if (s < 15) begin
        clock_ns = clock_ns;
      end else if (s < 70) begin
        clock_ns = clock_ns + 64'($urandom_range(1, 5000));
      end else if (s < 92) begin
        clock_ns = clock_ns + 64'($urandom_range(5000, 4_000_000));
      end else begin
        clock_ns = clock_ns + (64'($urandom) << 2);
      end
      ct = clock_ns;
      st = ct - pick_latency_ns();
    end else if (r < 92) begin
      st = {$urandom, $urandom};
      ct = {$urandom, $urandom};
    end else begin
      ct = clock_ns - 64'($urandom_range(1, 1_000_000));
      st = ct - pick_latency_ns();
    end
  endtask

  task automatic test_random_traffic();
    logic [63:0] windows [6];
    logic [63:0] st;
    logic [63:0] ct;
    windows[0] = 64'd20_000;
    windows[1] = 64'd3_000_000;
    windows[2] = 64'd1;
    windows[3] = {$urandom, $urandom};
    windows[4] = ilhm_pkg::RATE_WINDOW_RST;
    windows[5] = ALL_ONES;
    clock_ns = {$urandom, $urandom};
    for (int ph = 0; ph < 6; ph++) begin
      wait_idle();
      apb_write(WINDOW_ADDR, windows[ph]);
      // one phase runs flat out on both sides, one with the sender only idling
      sender_idles    = (ph != 1);
      receiver_stalls = (ph != 1) && (ph != 4);
      repeat (PHASE_ITEMS) begin
        next_request(st, ct);
        send_request(st, ct);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst              = 1'b1;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    item_valid       = 1'b0;
    issue_time_ns    = '0;
    complete_time_ns = '0;
    errors           = 0;
    cycles           = 0;
    sender_idles     = 1'b1;
    receiver_stalls  = 1'b1;
    clock_ns         = '0;
    // model state after reset
    for (int i = 0; i < ilhm_pkg::NUM_BUCKETS; i++) begin
      bucket_hits[i] = '0;
    end
    for (int i = 0; i < ilhm_pkg::SHOWN_ENTRIES; i++) begin
      lat_hist[i] = '0;
    end
    seen_requests = '0;
    lat_accum     = '0;
    win_reqs      = '0;
    win_open_ns   = '0;
    win_len_ns    = ilhm_pkg::RATE_WINDOW_RST;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_bucket_bounds();
    test_window_register();
    test_random_traffic();

    wait_idle();
    if (errors == 0) begin
      $display("io_latency_histogram_monitor_top regression: pass");
    end else begin
      $display("io_latency_histogram_monitor_top regression: fail");
    end
    $finish;
  end

endmodule
